>>> hdl/sst_pkg.sv
// Shared types, token codes and keyword table for the source tokenizer.
package sst_pkg;

   localparam int KEYWORD_MAX_CHARS_DEF = 8;
   localparam int POSITION_WIDTH_DEF = 16;
   localparam int OFFSET_WIDTH_DEF = 24;
   localparam int KW_COUNT = 22;

   // Token kind codes.
   localparam logic [5:0] K_LPAREN = 6'd0;
   localparam logic [5:0] K_RPAREN = 6'd1;
   localparam logic [5:0] K_LBRACE = 6'd2;
   localparam logic [5:0] K_RBRACE = 6'd3;
   localparam logic [5:0] K_SEMI = 6'd4;
   localparam logic [5:0] K_COMMA = 6'd5;
   localparam logic [5:0] K_DOT = 6'd6;
   localparam logic [5:0] K_MINUS = 6'd7;
   localparam logic [5:0] K_PLUS = 6'd8;
   localparam logic [5:0] K_SLASH = 6'd9;
   localparam logic [5:0] K_STAR = 6'd10;
   localparam logic [5:0] K_PERCENT = 6'd11;
   localparam logic [5:0] K_COLON = 6'd12;
   localparam logic [5:0] K_BANG = 6'd13;
   localparam logic [5:0] K_EQUAL = 6'd15;
   localparam logic [5:0] K_LESS = 6'd17;
   localparam logic [5:0] K_GREATER = 6'd19;
   localparam logic [5:0] K_IDENT = 6'd21;
   localparam logic [5:0] K_STRING = 6'd22;
   localparam logic [5:0] K_NUMBER = 6'd23;
   localparam logic [5:0] K_COMMENT = 6'd46;
   localparam logic [5:0] K_ERROR = 6'd47;
   localparam logic [5:0] K_EOF = 6'd48;

   // Error codes.
   localparam logic [1:0] E_NONE = 2'd0;
   localparam logic [1:0] E_STRING = 2'd1;
   localparam logic [1:0] E_COMMENT = 2'd2;
   localparam logic [1:0] E_CHAR = 2'd3;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_NUMDOT, M_FRAC,
      M_STRING, M_SLASH, M_LINECMT, M_BLOCKCMT, M_OP
   } mode_type;

   // One result word as it leaves the block.
   typedef struct packed {
      logic [5:0]  token_kind;
      logic [1:0]  error_kind;
      logic [15:0] first_line;
      logic [15:0] first_column;
      logic [15:0] final_line;
      logic [15:0] final_column;
      logic [23:0] start_offset;
      logic [15:0] token_length;
      logic        last_of_run;
   } result_type;

   // Keyword spelling, first character in the low byte, zero padded.
   function automatic logic [63:0] kw_text(input int i);
      logic [63:0] t;
      t = '0;
      case (i)
         0: t = {"dna"};
         1: t = {"kaerb"};
         2: t = {"ssalc"};
         3: t = {"tsnoc"};
         4: t = {"eunitnoc"};
         5: t = {"esac"};
         6: t = {"tluafed"};
         7: t = {"esle"};
         8: t = {"eslaf"};
         9: t = {"rof"};
         10: t = {"nuf"};
         11: t = {"fi"};
         12: t = {"lin"};
         13: t = {"ro"};
         14: t = {"tnirp"};
         15: t = {"nruter"};
         16: t = {"repus"};
         17: t = {"hctiws"};
         18: t = {"siht"};
         19: t = {"eurt"};
         20: t = {"rav"};
         21: t = {"elihw"};
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [3:0] kw_len(input int i);
      logic [3:0] l;
      case (i)
         0, 9, 10, 12, 20: l = 4'd3;
         11, 13: l = 4'd2;
         5, 7, 18, 19: l = 4'd4;
         15, 17: l = 4'd6;
         6: l = 4'd7;
         4: l = 4'd8;
         default: l = 4'd5;
      endcase
      return l;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic word_char(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   endfunction

   function automatic logic [5:0] op_kind(input logic [7:0] op, input logic dbl);
      logic [5:0] base;
      case (op)
         "!": base = K_BANG;
         "=": base = K_EQUAL;
         "<": base = K_LESS;
         default: base = K_GREATER;
      endcase
      return dbl ? base + 6'd1 : base;
   endfunction

endpackage

>>> hdl/sst_if.sv
// Request and response channel interfaces of the source tokenizer.
interface sst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] src_byte;
   logic       end_of_source;
   modport source (output valid, output src_byte, output end_of_source, input ready);
   modport sink (input valid, input src_byte, input end_of_source, output ready);
endinterface

interface sst_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [1:0]  error_kind;
   logic [15:0] first_line;
   logic [15:0] first_column;
   logic [15:0] final_line;
   logic [15:0] final_column;
   logic [23:0] start_offset;
   logic [15:0] token_length;
   logic        last_of_run;
   modport source (output valid, output token_kind, output error_kind, output first_line,
                   output first_column, output final_line, output final_column,
                   output start_offset, output token_length, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input error_kind, input first_line,
                 input first_column, input final_line, input final_column,
                 input start_offset, input token_length, input last_of_run,
                 output ready);
endinterface

>>> hdl/sst_scan_core.sv
// Scanner state registers and the per-byte next-state and token logic.
module sst_scan_core #(
   parameter int KEYWORD_MAX_CHARS = sst_pkg::KEYWORD_MAX_CHARS_DEF,
   parameter int POSITION_WIDTH = sst_pkg::POSITION_WIDTH_DEF,
   parameter int OFFSET_WIDTH = sst_pkg::OFFSET_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            src_byte,
   input  logic                  end_of_source,
   output logic [1:0]            res_count,
   output sst_pkg::result_type   res [3]
);

   localparam int KW_IDX = $clog2(KEYWORD_MAX_CHARS);

   typedef struct packed {
      logic [POSITION_WIDTH-1:0] line;
      logic [POSITION_WIDTH-1:0] col;
      logic [OFFSET_WIDTH-1:0]   ofs;
   } loc_type;

   localparam loc_type LOC_RESET = '{line: POSITION_WIDTH'(1), col: POSITION_WIDTH'(1),
                                     ofs: '0};

   sst_pkg::mode_type                mode_ff, mode_in;
   logic [KEYWORD_MAX_CHARS-1:0][7:0] kw_ff, kw_in;
   logic [7:0]                       held_ff, held_in;
   loc_type                          start_ff, start_in, cur_ff, cur_in;
   logic [15:0]                      len_ff, len_in;

   function automatic loc_type adv_loc(input loc_type l, input logic [7:0] c);
      loc_type r;
      r = l;
      if (l.ofs != '1) r.ofs = l.ofs + 1'b1;
      if (c == 8'h0A) begin
         if (l.line != '1) r.line = l.line + 1'b1;
         r.col = POSITION_WIDTH'(1);
      end else if (l.col != '1) begin
         r.col = l.col + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [15:0] adv_len(input logic [15:0] l);
      return (l != 16'hFFFF) ? l + 16'd1 : l;
   endfunction

   function automatic sst_pkg::result_type mk(input logic [5:0] k, input logic [1:0] e,
                                               input loc_type s, input loc_type c,
                                               input logic [15:0] l);
      sst_pkg::result_type r;
      r.token_kind = k;
      r.error_kind = e;
      r.first_line = 16'(s.line);
      r.first_column = 16'(s.col);
      r.final_line = 16'(c.line);
      r.final_column = 16'(c.col);
      r.start_offset = 24'(s.ofs);
      r.token_length = l;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // Keyword lookup on the buffered characters.
   function automatic logic [5:0] word_kind(input logic [KEYWORD_MAX_CHARS-1:0][7:0] kb,
                                            input logic [15:0] l);
      logic [5:0] k;
      logic       hit;
      logic [63:0] t;
      k = sst_pkg::K_IDENT;
      for (int i = sst_pkg::KW_COUNT - 1; i >= 0; i--) begin
         t = sst_pkg::kw_text(i);
         hit = (l == 16'(sst_pkg::kw_len(i)));
         for (int j = 0; j < 8; j++) begin
            if ((j < int'(sst_pkg::kw_len(i))) && (kb[j] != t[8*j +: 8])) hit = 1'b0;
         end
         if (hit) k = 6'(24 + i);
      end
      return k;
   endfunction

   // Walk one byte through the scanner, collecting up to three tokens.
   always_comb begin
      logic [1:0] n;
      logic       fresh;
      mode_in = mode_ff;
      kw_in = kw_ff;
      held_in = held_ff;
      start_in = start_ff;
      cur_in = cur_ff;
      len_in = len_ff;
      n = 2'd0;
      fresh = 1'b0;
      for (int i = 0; i < 3; i++) res[i] = '0;
      if (end_of_source) begin
         case (mode_ff)
            sst_pkg::M_IDENT: begin
               res[n] = mk(word_kind(kw_ff, len_ff), sst_pkg::E_NONE, start_in, cur_in, len_in);
               n = n + 2'd1;
            end
            sst_pkg::M_INT, sst_pkg::M_FRAC: begin
               res[n] = mk(sst_pkg::K_NUMBER, sst_pkg::E_NONE, start_in, cur_in, len_in);
               n = n + 2'd1;
            end
            sst_pkg::M_NUMDOT: begin
               res[n] = mk(sst_pkg::K_NUMBER, sst_pkg::E_NONE, start_in, cur_in, len_in);
               n = n + 2'd1;
               start_in = cur_in;
               cur_in = adv_loc(cur_in, ".");
               len_in = 16'd1;
               res[n] = mk(sst_pkg::K_DOT, sst_pkg::E_NONE, start_in, cur_in, len_in);
               n = n + 2'd1;
            end
            sst_pkg::M_STRING: begin
               res[n] = mk(sst_pkg::K_ERROR, sst_pkg::E_STRING, start_in, cur_in, len_in);
               n = n + 2'd1;
            end
            sst_pkg::M_SLASH: begin
               res[n] = mk(sst_pkg::K_SLASH, sst_pkg::E_NONE, start_in, cur_in, len_in);
               n = n + 2'd1;
            end
            sst_pkg::M_LINECMT: begin
               res[n] = mk(sst_pkg::K_COMMENT, sst_pkg::E_NONE, start_in, cur_in, len_in);
               n = n + 2'd1;
            end
            sst_pkg::M_BLOCKCMT: begin
               res[n] = mk(sst_pkg::K_ERROR, sst_pkg::E_COMMENT, start_in, cur_in, len_in);
               n = n + 2'd1;
            end
            sst_pkg::M_OP: begin
               res[n] = mk(sst_pkg::op_kind(held_ff, 1'b0), sst_pkg::E_NONE, start_in, cur_in,
                           len_in);
               n = n + 2'd1;
            end
            default: ;
         endcase
         res[n] = mk(sst_pkg::K_EOF, sst_pkg::E_NONE, cur_in, cur_in, 16'd0);
         n = n + 2'd1;
         mode_in = sst_pkg::M_IDLE;
         kw_in = '0;
         held_in = '0;
         start_in = LOC_RESET;
         cur_in = LOC_RESET;
         len_in = '0;
      end else begin
         case (mode_ff)
            sst_pkg::M_IDENT: begin
               if (sst_pkg::word_char(src_byte) || sst_pkg::digit_char(src_byte)) begin
                  if (len_ff < 16'(KEYWORD_MAX_CHARS)) kw_in[len_ff[KW_IDX-1:0]] = src_byte;
                  cur_in = adv_loc(cur_in, src_byte);
                  len_in = adv_len(len_in);
               end else begin
                  res[n] = mk(word_kind(kw_ff, len_ff), sst_pkg::E_NONE, start_in, cur_in,
                              len_in);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            sst_pkg::M_INT: begin
               if (sst_pkg::digit_char(src_byte)) begin
                  cur_in = adv_loc(cur_in, src_byte);
                  len_in = adv_len(len_in);
               end else if (src_byte == ".") begin
                  mode_in = sst_pkg::M_NUMDOT;
               end else begin
                  res[n] = mk(sst_pkg::K_NUMBER, sst_pkg::E_NONE, start_in, cur_in, len_in);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            sst_pkg::M_NUMDOT: begin
               if (sst_pkg::digit_char(src_byte)) begin
                  cur_in = adv_loc(adv_loc(cur_in, "."), src_byte);
                  len_in = adv_len(adv_len(len_in));
                  mode_in = sst_pkg::M_FRAC;
               end else begin
                  res[n] = mk(sst_pkg::K_NUMBER, sst_pkg::E_NONE, start_in, cur_in, len_in);
                  n = n + 2'd1;
                  start_in = cur_in;
                  cur_in = adv_loc(cur_in, ".");
                  len_in = 16'd1;
                  res[n] = mk(sst_pkg::K_DOT, sst_pkg::E_NONE, start_in, cur_in, len_in);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            sst_pkg::M_FRAC: begin
               if (sst_pkg::digit_char(src_byte)) begin
                  cur_in = adv_loc(cur_in, src_byte);
                  len_in = adv_len(len_in);
               end else begin
                  res[n] = mk(sst_pkg::K_NUMBER, sst_pkg::E_NONE, start_in, cur_in, len_in);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            sst_pkg::M_STRING: begin
               cur_in = adv_loc(cur_in, src_byte);
               len_in = adv_len(len_in);
               if (src_byte == 8'h22) begin
                  res[n] = mk(sst_pkg::K_STRING, sst_pkg::E_NONE, start_in, cur_in, len_in);
                  n = n + 2'd1;
                  mode_in = sst_pkg::M_IDLE;
               end
            end
            sst_pkg::M_SLASH: begin
               if (src_byte == "/") begin
                  cur_in = adv_loc(cur_in, src_byte);
                  len_in = adv_len(len_in);
                  mode_in = sst_pkg::M_LINECMT;
               end else if (src_byte == "*") begin
                  cur_in = adv_loc(cur_in, src_byte);
                  len_in = adv_len(len_in);
                  held_in = '0;
                  mode_in = sst_pkg::M_BLOCKCMT;
               end else begin
                  res[n] = mk(sst_pkg::K_SLASH, sst_pkg::E_NONE, start_in, cur_in, len_in);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end
            end
            sst_pkg::M_LINECMT: begin
               if (src_byte == 8'h0A) begin
                  res[n] = mk(sst_pkg::K_COMMENT, sst_pkg::E_NONE, start_in, cur_in, len_in);
                  n = n + 2'd1;
                  fresh = 1'b1;
               end else begin
                  cur_in = adv_loc(cur_in, src_byte);
                  len_in = adv_len(len_in);
               end
            end
            sst_pkg::M_BLOCKCMT: begin
               cur_in = adv_loc(cur_in, src_byte);
               len_in = adv_len(len_in);
               if ((held_ff == "*") && (src_byte == "/")) begin
                  res[n] = mk(sst_pkg::K_COMMENT, sst_pkg::E_NONE, start_in, cur_in, len_in);
                  n = n + 2'd1;
                  held_in = '0;
                  mode_in = sst_pkg::M_IDLE;
               end else begin
                  held_in = src_byte;
               end
            end
            sst_pkg::M_OP: begin
               if (src_byte == "=") begin
                  cur_in = adv_loc(cur_in, src_byte);
                  len_in = adv_len(len_in);
                  res[n] = mk(sst_pkg::op_kind(held_ff, 1'b1), sst_pkg::E_NONE, start_in,
                              cur_in, len_in);
                  n = n + 2'd1;
                  held_in = '0;
                  mode_in = sst_pkg::M_IDLE;
               end else begin
                  res[n] = mk(sst_pkg::op_kind(held_ff, 1'b0), sst_pkg::E_NONE, start_in,
                              cur_in, len_in);
                  n = n + 2'd1;
                  held_in = '0;
                  fresh = 1'b1;
               end
            end
            default: fresh = 1'b1;
         endcase

         // A byte that begins a new token or is whitespace.
         if (fresh) begin
            mode_in = sst_pkg::M_IDLE;
            if ((src_byte == " ") || (src_byte == 8'h09) || (src_byte == 8'h0D) ||
                (src_byte == 8'h0A)) begin
               cur_in = adv_loc(cur_in, src_byte);
               len_in = adv_len(len_in);
            end else begin
               start_in = cur_in;
               cur_in = adv_loc(cur_in, src_byte);
               len_in = 16'd1;
               if (sst_pkg::word_char(src_byte)) begin
                  kw_in = '0;
                  kw_in[0] = src_byte;
                  mode_in = sst_pkg::M_IDENT;
               end else if (sst_pkg::digit_char(src_byte)) begin
                  mode_in = sst_pkg::M_INT;
               end else begin
                  case (src_byte)
                     "/": mode_in = sst_pkg::M_SLASH;
                     8'h22: mode_in = sst_pkg::M_STRING;
                     "!", "=", "<", ">": begin
                        held_in = src_byte;
                        mode_in = sst_pkg::M_OP;
                     end
                     default: begin
                        res[n] = mk(sst_pkg::K_ERROR, sst_pkg::E_CHAR, start_in, cur_in,
                                    len_in);
                        case (src_byte)
                           "(": res[n].token_kind = sst_pkg::K_LPAREN;
                           ")": res[n].token_kind = sst_pkg::K_RPAREN;
                           "{": res[n].token_kind = sst_pkg::K_LBRACE;
                           "}": res[n].token_kind = sst_pkg::K_RBRACE;
                           ";": res[n].token_kind = sst_pkg::K_SEMI;
                           ",": res[n].token_kind = sst_pkg::K_COMMA;
                           ".": res[n].token_kind = sst_pkg::K_DOT;
                           "-": res[n].token_kind = sst_pkg::K_MINUS;
                           "+": res[n].token_kind = sst_pkg::K_PLUS;
                           "*": res[n].token_kind = sst_pkg::K_STAR;
                           "%": res[n].token_kind = sst_pkg::K_PERCENT;
                           ":": res[n].token_kind = sst_pkg::K_COLON;
                           default: ;
                        endcase
                        if (res[n].token_kind != sst_pkg::K_ERROR)
                           res[n].error_kind = sst_pkg::E_NONE;
                        n = n + 2'd1;
                     end
                  endcase
               end
            end
         end
      end
      if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
      res_count = n;
   end

   // Scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sst_pkg::M_IDLE;
         kw_ff <= '0;
         held_ff <= '0;
         start_ff <= LOC_RESET;
         cur_ff <= LOC_RESET;
         len_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         kw_ff <= kw_in;
         held_ff <= held_in;
         start_ff <= start_in;
         cur_ff <= cur_in;
         len_ff <= len_in;
      end
   end

endmodule

>>> hdl/sst_rsp_queue.sv
// Four-entry result queue that takes up to three words a cycle.
module sst_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  sst_pkg::result_type push_data [3],
   input  logic                pop,
   output logic                room,
   output logic                not_empty,
   output sst_pkg::result_type head_data
);

   sst_pkg::result_type mem_ff [4];
   logic [1:0] head_ff, head_in, tail_ff, tail_in;
   logic [2:0] count_ff, count_in;

   assign room = (count_ff <= 3'd1);
   assign not_empty = (count_ff != 3'd0);
   assign head_data = mem_ff[head_ff];

   // Pointer and fill level update.
   always_comb begin
      head_in = head_ff + {1'b0, pop};
      tail_in = tail_ff + push_count;
      count_in = count_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (2'(k) < push_count) mem_ff[tail_ff + 2'(k)] <= push_data[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hdl/script_source_tokenizer.sv
// Top level of the streaming source tokenizer.
// A token is written into the result queue when the byte that completes it is accepted.
// Throughput: one byte per cycle while the four-word result queue holds at most one word;
// otherwise req ready is low, as after a byte that yields several tokens (up to three).
// Reset: synchronous, active high; returns to line 1, column 1, offset 0 and empties the queue.
module script_source_tokenizer #(
   parameter int KEYWORD_MAX_CHARS = sst_pkg::KEYWORD_MAX_CHARS_DEF,
   parameter int POSITION_WIDTH = sst_pkg::POSITION_WIDTH_DEF,
   parameter int OFFSET_WIDTH = sst_pkg::OFFSET_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   sst_req_if.sink   req_chan,
   sst_rsp_if.source rsp_chan
);

   logic                accept;
   logic                pop;
   logic                room;
   logic                not_empty;
   logic [1:0]          res_count;
   sst_pkg::result_type res [3];
   sst_pkg::result_type head;

   assign req_chan.ready = room;
   assign accept = req_chan.valid & room;
   assign pop = not_empty & rsp_chan.ready;

   sst_scan_core #(
      .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS),
      .POSITION_WIDTH(POSITION_WIDTH),
      .OFFSET_WIDTH(OFFSET_WIDTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .src_byte(req_chan.src_byte),
      .end_of_source(req_chan.end_of_source),
      .res_count(res_count),
      .res(res)
   );

   sst_rsp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_count(accept ? res_count : 2'd0),
      .push_data(res),
      .pop(pop),
      .room(room),
      .not_empty(not_empty),
      .head_data(head)
   );

   // Response word from the queue head.
   assign rsp_chan.valid = not_empty;
   assign rsp_chan.token_kind = head.token_kind;
   assign rsp_chan.error_kind = head.error_kind;
   assign rsp_chan.first_line = head.first_line;
   assign rsp_chan.first_column = head.first_column;
   assign rsp_chan.final_line = head.final_line;
   assign rsp_chan.final_column = head.final_column;
   assign rsp_chan.start_offset = head.start_offset;
   assign rsp_chan.token_length = head.token_length;
   assign rsp_chan.last_of_run = head.last_of_run;

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result queue not empty after reset");

   // End of source always yields at least the end-of-file word.
   a_eos_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.end_of_source) |-> (res_count != 2'd0))
      else $error("end of source produced no token");

   // An accepted byte with tokens leaves the queue non-empty.
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (accept && (res_count != 2'd0)) |=> rsp_chan.valid)
      else $error("pushed token not visible");

endmodule

>>> tb/sst_tb_pkg.sv
`timescale 1ns / 1ps
// Stimulus word type used by the tokenizer testbench.
package sst_tb_pkg;

   // One source byte as offered to the block.
   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_source;
   } src_word_type;
endpackage

>>> tb/script_source_tokenizer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming source tokenizer.
module script_source_tokenizer_test;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sst_req_if req_chan ();
   sst_rsp_if rsp_chan ();

   script_source_tokenizer u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   // Scanner state mirrored by the predictor.
   sst_pkg::mode_type lex_mode;
   logic [7:0]  kw_buf [8];
   logic [7:0]  held_op;
   logic [15:0] tok_line, tok_col, cur_line, cur_col, run_len;
   logic [23:0] tok_ofs, cur_ofs;

   sst_tb_pkg::src_word_type src_queue[$];
   sst_pkg::result_type      token_queue[$];
   sst_pkg::result_type      step_tokens[$];
   int           error_count = 0;
   int           hold_off = 0;

   task automatic report(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   function automatic void lex_reset();
      lex_mode = sst_pkg::M_IDLE;
      foreach (kw_buf[i]) kw_buf[i] = 8'd0;
      held_op = 8'd0;
      tok_line = 16'd1; tok_col = 16'd1; tok_ofs = 24'd0;
      cur_line = 16'd1; cur_col = 16'd1; cur_ofs = 24'd0;
      run_len = 16'd0;
   endfunction

   function automatic void consume(input logic [7:0] b);
      if (cur_ofs != 24'hFFFFFF) cur_ofs++;
      if (b == 8'h0A) begin
         if (cur_line != 16'hFFFF) cur_line++;
         cur_col = 16'd1;
      end else if (cur_col != 16'hFFFF) begin
         cur_col++;
      end
      if (run_len != 16'hFFFF) run_len++;
   endfunction

   function automatic void mark_start();
      tok_line = cur_line; tok_col = cur_col; tok_ofs = cur_ofs;
      run_len = 16'd0;
   endfunction

   function automatic void push_token(input logic [5:0] kind, input logic [1:0] err);
      sst_pkg::result_type r;
      if (step_tokens.size() >= 3) return;
      r.token_kind = kind; r.error_kind = err;
      r.first_line = tok_line; r.first_column = tok_col;
      r.final_line = cur_line; r.final_column = cur_col;
      r.start_offset = tok_ofs; r.token_length = run_len;
      r.last_of_run = 1'b0;
      step_tokens.push_back(r);
   endfunction

   // Keyword lookup on the buffered characters of the word.
   function automatic logic [5:0] word_kind();
      string words [22] = '{"and", "break", "class", "const", "continue", "case", "default",
                            "else", "false", "for", "fun", "if", "nil", "or", "print",
                            "return", "super", "switch", "this", "true", "var", "while"};
      bit hit;
      for (int k = 0; k < 22; k++) begin
         if (run_len == words[k].len()) begin
            hit = 1'b1;
            for (int j = 0; j < words[k].len(); j++)
               if (kw_buf[j] != words[k][j]) hit = 1'b0;
            if (hit) return 6'(24 + k);
         end
      end
      return sst_pkg::K_IDENT;
   endfunction

   function automatic logic [5:0] op_code(input logic [7:0] op, input bit dbl);
      logic [5:0] base;
      case (op)
         "!": base = sst_pkg::K_BANG;
         "=": base = sst_pkg::K_EQUAL;
         "<": base = sst_pkg::K_LESS;
         default: base = sst_pkg::K_GREATER;
      endcase
      return dbl ? base + 6'd1 : base;
   endfunction

   function automatic bit digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic void flush_number_dot();
      push_token(sst_pkg::K_NUMBER, sst_pkg::E_NONE);
      mark_start();
      consume(".");
      push_token(sst_pkg::K_DOT, sst_pkg::E_NONE);
   endfunction

   // Scans a byte from the idle state.
   function automatic void scan_fresh(input logic [7:0] b);
      logic [5:0] single;
      bit found;
      lex_mode = sst_pkg::M_IDLE;
      if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
         consume(b);
         return;
      end
      mark_start();
      consume(b);
      if (letter(b)) begin
         foreach (kw_buf[i]) kw_buf[i] = 8'd0;
         kw_buf[0] = b;
         lex_mode = sst_pkg::M_IDENT;
         return;
      end
      if (digit(b)) begin
         lex_mode = sst_pkg::M_INT;
         return;
      end
      found = 1'b1;
      single = sst_pkg::K_ERROR;
      case (b)
         "(": single = sst_pkg::K_LPAREN;
         ")": single = sst_pkg::K_RPAREN;
         "{": single = sst_pkg::K_LBRACE;
         "}": single = sst_pkg::K_RBRACE;
         ";": single = sst_pkg::K_SEMI;
         ",": single = sst_pkg::K_COMMA;
         ".": single = sst_pkg::K_DOT;
         "-": single = sst_pkg::K_MINUS;
         "+": single = sst_pkg::K_PLUS;
         "*": single = sst_pkg::K_STAR;
         "%": single = sst_pkg::K_PERCENT;
         ":": single = sst_pkg::K_COLON;
         "/": begin lex_mode = sst_pkg::M_SLASH; return; end
         "\"": begin lex_mode = sst_pkg::M_STRING; return; end
         "!", "=", "<", ">": begin
            held_op = b;
            lex_mode = sst_pkg::M_OP;
            return;
         end
         default: found = 1'b0;
      endcase
      if (found) push_token(single, sst_pkg::E_NONE);
      else push_token(sst_pkg::K_ERROR, sst_pkg::E_CHAR);
   endfunction

   // Computes the tokens caused by one source word and appends them.
   function automatic void predict_tokens(input sst_tb_pkg::src_word_type w);
      logic [7:0] b;
      bit fresh;
      b = w.src_byte;
      fresh = 1'b0;
      step_tokens.delete();
      if (w.end_of_source) begin
         case (lex_mode)
            sst_pkg::M_IDENT: push_token(word_kind(), sst_pkg::E_NONE);
            sst_pkg::M_INT, sst_pkg::M_FRAC: push_token(sst_pkg::K_NUMBER, sst_pkg::E_NONE);
            sst_pkg::M_NUMDOT: flush_number_dot();
            sst_pkg::M_STRING: push_token(sst_pkg::K_ERROR, sst_pkg::E_STRING);
            sst_pkg::M_SLASH: push_token(sst_pkg::K_SLASH, sst_pkg::E_NONE);
            sst_pkg::M_LINECMT: push_token(sst_pkg::K_COMMENT, sst_pkg::E_NONE);
            sst_pkg::M_BLOCKCMT: push_token(sst_pkg::K_ERROR, sst_pkg::E_COMMENT);
            sst_pkg::M_OP: push_token(op_code(held_op, 1'b0), sst_pkg::E_NONE);
            default: ;
         endcase
         mark_start();
         push_token(sst_pkg::K_EOF, sst_pkg::E_NONE);
         lex_reset();
      end else begin
         case (lex_mode)
            sst_pkg::M_IDENT:
               if (letter(b) || digit(b)) begin
                  if (run_len < 8) kw_buf[run_len[2:0]] = b;
                  consume(b);
               end else begin
                  push_token(word_kind(), sst_pkg::E_NONE);
                  fresh = 1'b1;
               end
            sst_pkg::M_INT:
               if (digit(b)) consume(b);
               else if (b == ".") lex_mode = sst_pkg::M_NUMDOT;
               else begin push_token(sst_pkg::K_NUMBER, sst_pkg::E_NONE); fresh = 1'b1; end
            sst_pkg::M_NUMDOT:
               if (digit(b)) begin
                  consume(".");
                  consume(b);
                  lex_mode = sst_pkg::M_FRAC;
               end else begin
                  flush_number_dot();
                  fresh = 1'b1;
               end
            sst_pkg::M_FRAC:
               if (digit(b)) consume(b);
               else begin push_token(sst_pkg::K_NUMBER, sst_pkg::E_NONE); fresh = 1'b1; end
            sst_pkg::M_STRING: begin
               consume(b);
               if (b == "\"") begin
                  push_token(sst_pkg::K_STRING, sst_pkg::E_NONE);
                  lex_mode = sst_pkg::M_IDLE;
               end
            end
            sst_pkg::M_SLASH:
               if (b == "/") begin
                  consume(b);
                  lex_mode = sst_pkg::M_LINECMT;
               end else if (b == "*") begin
                  consume(b);
                  held_op = 8'd0;
                  lex_mode = sst_pkg::M_BLOCKCMT;
               end else begin
                  push_token(sst_pkg::K_SLASH, sst_pkg::E_NONE);
                  fresh = 1'b1;
               end
            sst_pkg::M_LINECMT:
               if (b == 8'h0A) begin
                  push_token(sst_pkg::K_COMMENT, sst_pkg::E_NONE);
                  fresh = 1'b1;
               end else begin
                  consume(b);
               end
            sst_pkg::M_BLOCKCMT: begin
               consume(b);
               if (held_op == "*" && b == "/") begin
                  push_token(sst_pkg::K_COMMENT, sst_pkg::E_NONE);
                  held_op = 8'd0;
                  lex_mode = sst_pkg::M_IDLE;
               end else begin
                  held_op = b;
               end
            end
            sst_pkg::M_OP:
               if (b == "=") begin
                  consume(b);
                  push_token(op_code(held_op, 1'b1), sst_pkg::E_NONE);
                  held_op = 8'd0;
                  lex_mode = sst_pkg::M_IDLE;
               end else begin
                  push_token(op_code(held_op, 1'b0), sst_pkg::E_NONE);
                  held_op = 8'd0;
                  fresh = 1'b1;
               end
            default: fresh = 1'b1;
         endcase
         if (fresh) scan_fresh(b);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
   endfunction

   // Stimulus helpers.
   task automatic put_byte(input logic [7:0] b);
      sst_tb_pkg::src_word_type w;
      w.src_byte = b;
      w.end_of_source = 1'b0;
      src_queue.push_back(w);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic put_eof(input logic [7:0] junk);
      sst_tb_pkg::src_word_type w;
      w.src_byte = junk;
      w.end_of_source = 1'b1;
      src_queue.push_back(w);
   endtask

   function automatic string pick_fragment();
      string frags [30] = '{"and ", "break", "class", "const", "continue", "case", "default",
                            "else", "false", "for", "fun", "if", "nil", "or", "print",
                            "return", "super", "switch", "this", "true", "var", "while",
                            "x_9", "3.14", "7.", "\"s\n\"", "// c\n", "/* * */", "<=", "!x"};
      return frags[$urandom_range(0, 29)];
   endfunction

   function automatic logic [7:0] pick_noise();
      string pun = "(){};,.-+*/%:!=<>\" \t\r\n";
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 255));
         1: return pun[$urandom_range(0, pun.len() - 1)];
         2: return 8'("0" + $urandom_range(0, 9));
         default: return 8'("a" + $urandom_range(0, 25));
      endcase
   endfunction

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   // Driver: offers queued words, with random gaps while 40 or more wait; nonblocking only.
   int  send_gap = 0;
   bit  pause_req = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.src_byte <= 8'd0;
         req_chan.end_of_source <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_tokens({req_chan.src_byte, req_chan.end_of_source});
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pause_req && token_queue.size() != 0) begin
               req_chan.valid <= 1'b0;
            end else if (src_queue.size() > 0) begin
               sst_tb_pkg::src_word_type w;
               w = src_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.src_byte <= w.src_byte;
               req_chan.end_of_source <= w.end_of_source;
               send_gap <= (src_queue.size() < 40) ? 0 : gap_len();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure, long stalls on request, and the token check.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (token_queue.size() == 0) begin
               report($sformatf("unexpected token kind %0d", rsp_chan.token_kind));
            end else begin
               sst_pkg::result_type e;
               e = token_queue.pop_front();
               if (rsp_chan.token_kind !== e.token_kind)
                  report($sformatf("token_kind %0d want %0d", rsp_chan.token_kind, e.token_kind));
               if (rsp_chan.error_kind !== e.error_kind)
                  report($sformatf("error_kind %0d want %0d", rsp_chan.error_kind, e.error_kind));
               if (rsp_chan.first_line !== e.first_line)
                  report($sformatf("first_line %0d want %0d", rsp_chan.first_line, e.first_line));
               if (rsp_chan.first_column !== e.first_column)
                  report($sformatf("first_column %0d want %0d", rsp_chan.first_column,
                                   e.first_column));
               if (rsp_chan.final_line !== e.final_line)
                  report($sformatf("final_line %0d want %0d", rsp_chan.final_line, e.final_line));
               if (rsp_chan.final_column !== e.final_column)
                  report($sformatf("final_column %0d want %0d", rsp_chan.final_column,
                                   e.final_column));
               if (rsp_chan.start_offset !== e.start_offset)
                  report($sformatf("start_offset %0d want %0d", rsp_chan.start_offset,
                                   e.start_offset));
               if (rsp_chan.token_length !== e.token_length)
                  report($sformatf("token_length %0d want %0d", rsp_chan.token_length,
                                   e.token_length));
               if (rsp_chan.last_of_run !== e.last_of_run)
                  report($sformatf("last_of_run %0d want %0d", rsp_chan.last_of_run,
                                   e.last_of_run));
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
         end
      end
   end

   // Stimulus, phases and the end of the run.
   initial begin
      int n;
      string s;
      lex_reset();
      req_chan.valid = 1'b0;
      req_chan.src_byte = 8'd0;
      req_chan.end_of_source = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: punctuation, operators, held dot, slashes, keywords, errors.
      put_text("(){};,.-+*%:!!=");
      put_text("==<<=>>= 12.5 7.x a/b");
      put_byte(8'h00); put_byte(8'hFF); put_byte(8'h80);
      put_text("super switch abcdefghij //c\n/*a**/\"s\n\"");
      put_eof(8'hA5);
      put_text("9."); put_eof(8'h00);
      put_text("/* x"); put_eof(8'h7F);
      put_text("\"open"); put_eof(8'h00);
      put_text("<"); put_eof(8'h00);
      put_text("/"); put_eof(8'h00);
      put_text("// tail"); put_eof(8'h00);

      // Long receiver stall while bytes keep coming, so the input backs up.
      wait (src_queue.size() == 0);
      hold_off <= 400;
      put_text("(((((((((( 1.a 2.b ))))))))");
      wait (src_queue.size() == 0);

      // Sender pause until every token has drained.
      pause_req <= 1'b1;
      put_text("x;");
      wait (src_queue.size() == 0 && token_queue.size() == 0);
      pause_req <= 1'b0;

      // Random part: mostly well-formed fragments, some noise, sources ended now and then.
      n = 0;
      while (n < 150) begin
         if ($urandom_range(0, 2) != 0) begin
            s = pick_fragment();
            put_text(s);
            n += s.len();
            put_byte(($urandom_range(0, 1) == 0) ? " " : pick_noise());
            n++;
         end else begin
            put_byte(pick_noise());
            n++;
         end
         if ($urandom_range(0, 30) == 0) begin
            put_eof(8'($urandom_range(0, 255)));
            n++;
         end
         if (src_queue.size() > 60) wait (src_queue.size() < 20);
      end
      put_eof(8'd0);

      wait (src_queue.size() == 0 && !req_chan.valid);
      wait (token_queue.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/sst_pkg.sv
hdl/sst_if.sv
hdl/sst_scan_core.sv
hdl/sst_rsp_queue.sv
hdl/script_source_tokenizer.sv
tb/sst_tb_pkg.sv
tb/script_source_tokenizer_test.sv
